/* design/anp_pkg.sv */
// ----------------------------------------------------------------------------
// anp_pkg
// Shared types, character codes and helpers for the ASCII number parser.
// ----------------------------------------------------------------------------
package anp_pkg;

  // Width of the accumulator; the result port stays 32 bits wide.
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;
  localparam int unsigned OUT_EXT_W   = (VALUE_WIDTH > OUT_WIDTH) ? VALUE_WIDTH : OUT_WIDTH;
  localparam int unsigned CH_WIDTH    = 7;

  typedef logic [CH_WIDTH-1:0]    ch_t;
  typedef logic [VALUE_WIDTH-1:0] accum_t;

  // Character codes
  localparam ch_t CH_NUL     = 7'h00;
  localparam ch_t CH_ZERO    = 7'h30;  // '0'
  localparam ch_t CH_SEVEN   = 7'h37;  // '7'
  localparam ch_t CH_NINE    = 7'h39;  // '9'
  localparam ch_t CH_UPPER_A = 7'h41;  // 'A'
  localparam ch_t CH_UPPER_F = 7'h46;  // 'F'
  localparam ch_t CH_LOWER_A = 7'h61;  // 'a'
  localparam ch_t CH_LOWER_F = 7'h66;  // 'f'
  localparam ch_t CH_X       = 7'h78;  // 'x'
  localparam ch_t CH_MINUS   = 7'h2D;  // '-'

  localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_ACCUM  = 2'd1,
    PH_REJECT = 2'd2
  } phase_e;

  // Result of classifying one character against the current radix
  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } digit_t;

  // Sign-extend an accumulator value and keep the low 32 bits
  function automatic logic signed [OUT_WIDTH-1:0] to_output(accum_t v);
    logic [OUT_EXT_W-1:0] ext;
    ext = OUT_EXT_W'($signed(v));
    return $signed(ext[OUT_WIDTH-1:0]);
  endfunction

endpackage

/* design/anp_digit.sv */
// ----------------------------------------------------------------------------
// anp_digit
// Classify one character as a digit of octal, decimal or hex and decode it.
// ----------------------------------------------------------------------------
module anp_digit (
  input  anp_pkg::ch_t    ch_i,
  input  anp_pkg::radix_e radix_i,
  output anp_pkg::digit_t digit_o
);
  import anp_pkg::*;

  logic [3:0] num_val;
  logic [3:0] upper_val;
  logic [3:0] lower_val;

  assign num_val   = 4'(ch_i - CH_ZERO);
  assign upper_val = 4'(ch_i - CH_UPPER_A) + HEX_ALPHA_BASE;
  assign lower_val = 4'(ch_i - CH_LOWER_A) + HEX_ALPHA_BASE;

  always_comb begin
    digit_o = '0;
    case (radix_i)
      RADIX_OCT: begin
        if (ch_i inside {[CH_ZERO:CH_SEVEN]}) begin
          digit_o = '{ok: 1'b1, digit: num_val};
        end
      end
      RADIX_HEX: begin
        if (ch_i inside {[CH_ZERO:CH_NINE]}) begin
          digit_o = '{ok: 1'b1, digit: num_val};
        end else if (ch_i inside {[CH_UPPER_A:CH_UPPER_F]}) begin
          digit_o = '{ok: 1'b1, digit: upper_val};
        end else if (ch_i inside {[CH_LOWER_A:CH_LOWER_F]}) begin
          digit_o = '{ok: 1'b1, digit: lower_val};
        end
      end
      default: begin
        if (ch_i inside {[CH_ZERO:CH_NINE]}) begin
          digit_o = '{ok: 1'b1, digit: num_val};
        end
      end
    endcase
  end

endmodule

/* design/ascii_number_parser_unit.sv */
// ----------------------------------------------------------------------------
// ascii_number_parser_unit
// Parse a stream of ASCII characters into a signed integer, radix by prefix.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o   | ch_i (7 bit)
//  out     | output    | out_valid_o / out_ready_i | value_o (s32), rejected_o
//
//  One character per cycle, sustained while no terminator waits behind an
//  untaken result. A transfer lands in the input register; from there the
//  digit decode and shift-add update the parser state and, for a terminator,
//  load the result register, which holds the result until it transfers.
//  Reset clears the parser state and both valid flags.
//  Only a terminator needs the result register, so ordinary characters keep
//  flowing while a result waits; a terminator behind an untaken result stalls
//  the input for as long as out_ready_i stays low.
//
module ascii_number_parser_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  anp_pkg::ch_t         ch_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   value_o,
  output logic                 rejected_o
);
  import anp_pkg::*;

  // Input register
  logic   in_valid_q;
  ch_t    ch_q;

  // Parser state
  phase_e phase_q, phase_d;
  radix_e radix_q, radix_d;
  logic   negate_q, negate_d;
  accum_t accum_q, accum_d;

  // Result register
  logic                       out_valid_q;
  logic signed [OUT_WIDTH-1:0] value_q, value_d;
  logic                       rejected_q, rejected_d;

  logic   is_term;
  logic   advance;
  logic   in_xfer;
  digit_t dig;
  accum_t mac;
  accum_t final_val;

  assign is_term = (ch_q == CH_NUL);
  // Advance the held character unless it is a terminator and the result slot
  // is still occupied.
  assign advance    = in_valid_q && (!is_term || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  anp_digit u_digit (
    .ch_i    (ch_q),
    .radix_i (radix_q),
    .digit_o (dig)
  );

  // Multiply by the radix as shifts and adds, then add the new digit.
  always_comb begin
    case (radix_q)
      RADIX_OCT: mac = (accum_q << 3);
      RADIX_HEX: mac = (accum_q << 4);
      default:   mac = (accum_q << 3) + (accum_q << 1);
    endcase
    mac = mac + VALUE_WIDTH'(dig.digit);
  end

  assign final_val = negate_q ? (-accum_q) : accum_q;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (advance) begin
      if (is_term) begin
        phase_d = PH_FIRST;
      end else begin
        case (phase_q)
          PH_FIRST: begin
            if (ch_q != CH_MINUS) begin
              phase_d = PH_ACCUM;
            end
          end
          PH_ACCUM: begin
            if (!dig.ok) begin
              phase_d = PH_REJECT;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // Datapath and result
  always_comb begin
    radix_d    = radix_q;
    negate_d   = negate_q;
    accum_d    = accum_q;
    value_d    = value_q;
    rejected_d = rejected_q;
    if (advance) begin
      if (is_term) begin
        case (phase_q)
          PH_FIRST: begin
            value_d    = '0;
            rejected_d = 1'b0;
          end
          PH_ACCUM: begin
            value_d    = to_output(final_val);
            rejected_d = 1'b0;
          end
          default: begin
            value_d    = '0;
            rejected_d = 1'b1;
          end
        endcase
        radix_d  = RADIX_DEC;
        negate_d = 1'b0;
        accum_d  = '0;
      end else begin
        case (phase_q)
          PH_FIRST: begin
            if (ch_q == CH_MINUS) begin
              negate_d = 1'b1;
            end else if (ch_q == CH_ZERO) begin
              radix_d = RADIX_OCT;
            end else if (ch_q == CH_X) begin
              radix_d = RADIX_HEX;
            end else begin
              // Seed unchecked: any other first character counts as a digit
              radix_d = RADIX_DEC;
              accum_d = VALUE_WIDTH'(ch_q) - VALUE_WIDTH'(CH_ZERO);
            end
          end
          PH_ACCUM: begin
            accum_d = dig.ok ? mac : '0;
          end
          default: accum_d = accum_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_FIRST;
      radix_q     <= RADIX_DEC;
      negate_q    <= 1'b0;
      accum_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance && is_term) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      phase_q  <= phase_d;
      radix_q  <= radix_d;
      negate_q <= negate_d;
      accum_q  <= accum_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q <= ch_i;
    end
    value_q    <= value_d;
    rejected_q <= rejected_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign rejected_o  = rejected_q;

`ifndef NO_ASSERTIONS
  a_term_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_term) |=> (phase_q == PH_FIRST && accum_q == '0 && !negate_q))
    else $error("parser state not cleared after terminator");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> (value_o == '0))
    else $error("rejected result carries a non-zero value");

  a_reject_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_REJECT) |-> (accum_q == '0))
    else $error("accumulator not cleared in rejected phase");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && is_term && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked terminator");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds character strings into the parser and compares every returned number
// with a parser kept in the bench, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  import anp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned MAX_SHOWN    = 10;

  typedef struct packed {
    logic signed [31:0] value;
    logic               rejected;
  } number_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_q  = 1'b0;
  ch_t                ch_q        = CH_NUL;
  logic               out_ready_q = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [31:0] value_o;
  logic               rejected_o;

  // Bench-side parser state
  phase_e prs_phase  = PH_FIRST;
  radix_e prs_radix  = RADIX_DEC;
  logic   prs_negate = 1'b0;
  accum_t prs_accum  = '0;

  number_t     pending_numbers[$];
  int unsigned items_sent  = 0;
  int unsigned error_count = 0;
  bit          quiet_q     = 1'b0;
  int unsigned stall_left  = 0;

  ascii_number_parser_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_q),
    .value_o     (value_o),
    .rejected_o  (rejected_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #(200_000 * 12);
    $display("[ascii_number_parser_unit] ERROR");
    $finish;
  end

  // Digit value of c in radix r; returns 0 when c is no digit of r
  function automatic bit digit_of_radix(ch_t c, radix_e r, output logic [3:0] d);
    d = '0;
    if (c < CH_ZERO) return 1'b0;
    if (c <= CH_NINE && (r != RADIX_OCT || c <= CH_SEVEN)) begin
      d = 4'(c - CH_ZERO);
      return 1'b1;
    end
    if (r != RADIX_HEX) return 1'b0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = 4'(c - CH_UPPER_A) + HEX_ALPHA_BASE;
      return 1'b1;
    end
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = 4'(c - CH_LOWER_A) + HEX_ALPHA_BASE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the bench parser by one accepted character; queue a number on NUL
  task automatic advance_parser(input ch_t c);
    logic [3:0]         d;
    logic [63:0]        wide;
    accum_t             v;
    number_t            n;
    int unsigned        base;
    if (c == CH_NUL) begin
      v = '0;
      n.rejected = 1'b0;
      if (prs_phase == PH_ACCUM) begin
        v = prs_negate ? accum_t'(-prs_accum) : prs_accum;
      end else if (prs_phase != PH_FIRST) begin
        n.rejected = 1'b1;
      end
      wide = 64'($signed(v));
      n.value = wide[31:0];
      pending_numbers.push_back(n);
      prs_phase  = PH_FIRST;
      prs_radix  = RADIX_DEC;
      prs_negate = 1'b0;
      prs_accum  = '0;
    end else if (prs_phase == PH_FIRST) begin
      if (c == CH_MINUS) begin
        prs_negate = 1'b1;
      end else begin
        if (c == CH_ZERO) begin
          prs_radix = RADIX_OCT;
        end else if (c == CH_X) begin
          prs_radix = RADIX_HEX;
        end else begin
          prs_radix = RADIX_DEC;
          prs_accum = accum_t'(c) - accum_t'(CH_ZERO);
        end
        prs_phase = PH_ACCUM;
      end
    end else if (prs_phase == PH_ACCUM) begin
      if (digit_of_radix(c, prs_radix, d)) begin
        base = (prs_radix == RADIX_OCT) ? 8 : (prs_radix == RADIX_HEX) ? 16 : 10;
        prs_accum = prs_accum * accum_t'(base) + accum_t'(d);
      end else begin
        prs_accum = '0;
        prs_phase = PH_REJECT;
      end
    end
  endtask

  // Offer one character and hold it until the transfer; idle now and then first
  task automatic push_char(input ch_t c);
    if (!quiet_q && $urandom_range(99) < 6) begin
      in_valid_q <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_q <= 1'b1;
    ch_q       <= c;
    do @(posedge clk_i); while (!in_ready_o);
    advance_parser(c);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(ch_t'(s[i]));
    push_char(CH_NUL);
  endtask

  function automatic ch_t pick_digit(radix_e r);
    case (r)
      RADIX_OCT: return CH_ZERO + ch_t'($urandom_range(0, 7));
      RADIX_HEX: begin
        case ($urandom_range(0, 2))
          0:       return CH_ZERO + ch_t'($urandom_range(0, 9));
          1:       return CH_UPPER_A + ch_t'($urandom_range(0, 5));
          default: return CH_LOWER_A + ch_t'($urandom_range(0, 5));
        endcase
      end
      default:   return CH_ZERO + ch_t'($urandom_range(0, 9));
    endcase
  endfunction

  // One string: mostly a well-formed number, sometimes with a bad character,
  // sometimes plain noise that may hold terminators of its own
  task automatic send_random_string();
    ch_t         chars[$];
    radix_e      r;
    int unsigned ndig;
    int unsigned lead;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(0, 8)) chars.push_back(ch_t'($urandom_range(0, 127)));
    end else begin
      repeat (($urandom_range(9) < 3) ? $urandom_range(1, 3) : 0) chars.push_back(CH_MINUS);
      lead = chars.size();
      case ($urandom_range(0, 2))
        0:       r = RADIX_OCT;
        1:       r = RADIX_HEX;
        default: r = RADIX_DEC;
      endcase
      ndig = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 9);
      if (r == RADIX_OCT) begin
        chars.push_back(CH_ZERO);
      end else if (r == RADIX_HEX) begin
        chars.push_back(CH_X);
      end else if ($urandom_range(9) == 0) begin
        chars.push_back(ch_t'($urandom_range(1, 127)));  // unchecked seed character
      end else begin
        chars.push_back(CH_ZERO + ch_t'($urandom_range(1, 9)));
      end
      repeat (ndig) chars.push_back(pick_digit(r));
      // corrupt one character after the prefix
      if ($urandom_range(99) < 15 && chars.size() > lead + 1) begin
        chars[$urandom_range(lead + 1, chars.size() - 1)] = ch_t'($urandom_range(1, 127));
      end
    end
    foreach (chars[i]) push_char(chars[i]);
    push_char(CH_NUL);
  endtask

  // Receiver: random stalls, rare long ones, none while quiet
  always @(posedge clk_i) begin
    number_t exp_n;
    if (rst_ni && out_valid_o && out_ready_q) begin
      if (pending_numbers.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("unexpected result: value %0d rejected %0b", value_o, rejected_o);
      end else begin
        exp_n = pending_numbers.pop_front();
        if (value_o !== exp_n.value || rejected_o !== exp_n.rejected) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("mismatch: expected value %0d rejected %0b, got value %0d rejected %0b",
                     exp_n.value, exp_n.rejected, value_o, rejected_o);
        end
      end
    end
    if (quiet_q) begin
      out_ready_q <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_q <= 1'b0;
    end else if ($urandom_range(999) < 3) begin
      stall_left = $urandom_range(20, 40);
      out_ready_q <= 1'b0;
    end else begin
      out_ready_q <= ($urandom_range(99) >= 7);
    end
  end

  // Extremes, every radix and each corner of the prefix and digit rules
  task automatic test_directed();
    send_text("");           // empty string
    send_text("---");        // minus only
    send_text("-x1F");
    send_text("0");          // octal prefix with no digits
    send_text("0777");
    send_text("08");         // 8 is no octal digit
    send_text("xaBcDeF");
    send_text("x1g2");       // bad hex digit, rest dropped
    send_text("x7FFFFFFF");
    send_text("-x80000000");
    send_text("1-2");        // minus after the first digit
    send_text("9z55");
    send_text("/");          // unchecked seed below '0'
    push_char(ch_t'(1));
    push_char(CH_NUL);
    push_char(ch_t'(127));   // highest code as seed and as digit
    push_char(ch_t'(127));
    push_char(CH_NUL);
  endtask

  task automatic test_random_mix(input int unsigned upto);
    while (items_sent < upto) send_random_string();
  endtask

  // Hold the sender until the parser has returned everything
  task automatic test_drain_pause();
    in_valid_q <= 1'b0;
    @(posedge clk_i);
    while (pending_numbers.size() != 0) @(posedge clk_i);
  endtask

  // Back-to-back transfers with both sides always ready
  task automatic test_quiet_stretch(input int unsigned count);
    int unsigned upto;
    upto    = items_sent + count;
    quiet_q = 1'b1;
    while (items_sent < upto) send_random_string();
    quiet_q = 1'b0;
  endtask

  initial begin
    int unsigned guard;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(items_sent + RANDOM_ITEMS / 3);
    test_drain_pause();
    test_quiet_stretch(RANDOM_ITEMS / 4);
    test_random_mix(RANDOM_ITEMS + 60);
    in_valid_q <= 1'b0;
    guard = 0;
    while (pending_numbers.size() != 0 && guard < 10_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_numbers.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("[ascii_number_parser_unit] OK");
    end else begin
      $display("[ascii_number_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

/* ascii_number_parser_unit.f */
design/anp_pkg.sv
design/anp_digit.sv
design/ascii_number_parser_unit.sv
tb/testbench.sv
